FILE: rtl/core/quad_window_comparator_logic_macros.svh
// ----------------------------------------------------------------------------
// quad window comparator assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef QUAD_WINDOW_COMPARATOR_LOGIC_MACROS_SVH
`define QUAD_WINDOW_COMPARATOR_LOGIC_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define QWC_ASSERT_IMP(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
        else $error("qwc assertion failed: same-cycle implication");

// next-cycle implication
`define QWC_ASSERT_NXT(label, clk, rstn, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
        else $error("qwc assertion failed: next-cycle implication");

`else

`define QWC_ASSERT_IMP(label, clk, rstn, pre, post)
`define QWC_ASSERT_NXT(label, clk, rstn, pre, post)

`endif

`endif

FILE: rtl/core/qwc_pkg.sv
// ----------------------------------------------------------------------------
// qwc_pkg
// shared types and constants of the quad window comparator
// ----------------------------------------------------------------------------
`default_nettype none

package qwc_pkg;

    // field widths fixed by the register map and the cv inputs
    localparam int KNOB_W      = 15;
    localparam int CV_W        = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    // 0.1 V hysteresis at doubled scale (205 lsb each side, times two)
    localparam int HYST2 = 410;

    // register map
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_A = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_D = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_A  = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_D  = 4'd7;

    // knob reset values
    localparam logic signed [KNOB_W-1:0] CENTER_RESET = 15'sd0;
    localparam logic [KNOB_W-1:0]        WIDTH_RESET  = 15'd2048;

    // channel codes
    localparam logic [1:0] CH_A = 2'd0;
    localparam logic [1:0] CH_D = 2'd3;

    // hysteretic window state
    typedef enum logic [1:0] {
        ZONE_NONE   = 2'd0,
        ZONE_BELOW  = 2'd1,
        ZONE_INSIDE = 2'd2,
        ZONE_ABOVE  = 2'd3
    } zone_t;

    // and / or / xor of two flags, bit0 and, bit1 or, bit2 xor
    function automatic logic [2:0] logic3(input logic a, input logic b);
        logic [2:0] r;
        r = {a ^ b, a | b, a & b};
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qwc_zone.sv
// ----------------------------------------------------------------------------
// qwc_zone
// window edges and hysteretic zone update for one channel sample
// ----------------------------------------------------------------------------
`default_nettype none

module qwc_zone #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  wire logic signed [qwc_pkg::KNOB_W-1:0] center_knob,
    input  wire logic        [qwc_pkg::KNOB_W-1:0] width_knob,
    input  wire logic signed [qwc_pkg::CV_W-1:0]   shift_cv,
    input  wire logic signed [qwc_pkg::CV_W-1:0]   size_cv,
    input  wire qwc_pkg::zone_t                    zone_prev,
    output qwc_pkg::zone_t                         zone_next
);

    // doubled-scale compare width: covers 2*sample and the widened edges
    localparam int EDGE_W = 21;
    localparam int CW     = (SAMPLE_WIDTH + 2 > EDGE_W) ? SAMPLE_WIDTH + 2 : EDGE_W;
    localparam int SUM_W  = qwc_pkg::CV_W + 1;

    localparam logic signed [CW-1:0] HYST_X = CW'(qwc_pkg::HYST2);

    logic signed [SUM_W-1:0] center_sum;
    logic signed [SUM_W-1:0] size_raw;
    logic signed [SUM_W-1:0] size_clamped;
    logic signed [CW-1:0]    center_x;
    logic signed [CW-1:0]    size_x;
    logic signed [CW-1:0]    sample_x;
    logic signed [CW-1:0]    hi2;
    logic signed [CW-1:0]    lo2;
    logic signed [CW-1:0]    s2;
    logic                    above_hit;
    logic                    below_hit;
    logic                    inner_lo;
    logic                    inner_hi;

    // center and width sums, width clamped to at least one lsb
    always_comb begin
        center_sum = SUM_W'(center_knob) + SUM_W'(shift_cv);
        size_raw   = $signed({2'b00, width_knob}) + SUM_W'(size_cv);
        if (size_raw < $signed(SUM_W'(1))) begin
            size_clamped = SUM_W'(1);
        end else begin
            size_clamped = size_raw;
        end
    end

    // doubled-scale edges
    always_comb begin
        center_x = CW'(center_sum);
        size_x   = CW'(size_clamped);
        sample_x = CW'(sample);
        hi2      = center_x + center_x + size_x;
        lo2      = center_x + center_x - size_x;
        s2       = sample_x + sample_x;
    end

    // edge compares with the hysteresis band
    always_comb begin
        above_hit = s2 > (hi2 + HYST_X);
        below_hit = s2 < (lo2 - HYST_X);
        inner_lo  = s2 >= (lo2 + HYST_X);
        inner_hi  = s2 <= (hi2 - HYST_X);
    end

    // zone transition
    always_comb begin
        zone_next = zone_prev;
        if (above_hit) begin
            zone_next = qwc_pkg::ZONE_ABOVE;
        end else if (below_hit) begin
            zone_next = qwc_pkg::ZONE_BELOW;
        end else if ((zone_prev == qwc_pkg::ZONE_ABOVE && inner_hi) ||
                     (zone_prev == qwc_pkg::ZONE_BELOW && inner_lo) ||
                     (zone_prev != qwc_pkg::ZONE_INSIDE && inner_lo && inner_hi)) begin
            zone_next = qwc_pkg::ZONE_INSIDE;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/quad_window_comparator_logic.sv
// ----------------------------------------------------------------------------
// quad_window_comparator_logic
// four-channel window comparator with hysteresis and pair logic
// ----------------------------------------------------------------------------
// Samples arrive one channel per beat in the fixed order A, B, C, D; an
// internal frame counter starts at A after reset and advances on every beat.
// Each input beat gives exactly one result beat. The block takes one beat per
// clock while the output is not stalled, and holds two stages, an input
// register and a result register; the zone update between them is a single
// pass of adds and compares, and the per-channel zone state is read and
// written in that pass, which sets the one-beat-per-cycle rate. The knob
// registers are written through the cfg port and should be changed only
// while no beat is in flight.
`default_nettype none

`include "quad_window_comparator_logic_macros.svh"

module quad_window_comparator_logic #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    // configuration write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [qwc_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  wire logic [qwc_pkg::CFG_DATA_W-1:0]         cfg_wdata,

    // sample channel
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]         s_sample,
    input  wire logic                                   s_connected,
    input  wire logic signed [qwc_pkg::CV_W-1:0]        s_shift_cv,
    input  wire logic signed [qwc_pkg::CV_W-1:0]        s_size_cv,

    // result channel
    output logic                                        m_valid,
    input  wire logic                                   m_ready,
    output logic [1:0]                                  m_channel,
    output logic [1:0]                                  m_zone,
    output logic                                        m_frame_end,
    output logic [2:0]                                  m_ab_logic,
    output logic                                        m_ab_toggle,
    output logic [2:0]                                  m_cd_logic,
    output logic                                        m_cd_toggle,
    output logic [2:0]                                  m_pairs_logic
);

    // knob registers
    logic signed [qwc_pkg::KNOB_W-1:0] center_reg [4];
    logic        [qwc_pkg::KNOB_W-1:0] width_reg  [4];

    // input stage
    logic                              in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0]    in_sample_reg;
    logic                              in_connected_reg;
    logic signed [qwc_pkg::CV_W-1:0]   in_shift_reg;
    logic signed [qwc_pkg::CV_W-1:0]   in_size_reg;

    // channel state
    qwc_pkg::zone_t                    zone_store_reg [4];
    logic signed [SAMPLE_WIDTH-1:0]    carried_reg;
    logic [1:0]                        pos_reg;
    logic                              ab_xor_last_reg;
    logic                              cd_xor_last_reg;
    logic                              ab_flop_reg;
    logic                              cd_flop_reg;

    // result stage
    logic                              out_valid_reg;
    logic [1:0]                        out_channel_reg;
    qwc_pkg::zone_t                    out_zone_reg;
    logic                              out_frame_end_reg;
    logic [2:0]                        out_ab_logic_reg;
    logic                              out_ab_toggle_reg;
    logic [2:0]                        out_cd_logic_reg;
    logic                              out_cd_toggle_reg;
    logic [2:0]                        out_pairs_logic_reg;

    // datapath
    logic                              advance;
    logic                              frame_end;
    logic signed [SAMPLE_WIDTH-1:0]    used_sample;
    qwc_pkg::zone_t                    zone_prev;
    qwc_pkg::zone_t                    zone_new;
    logic                              in_a;
    logic                              in_b;
    logic                              in_c;
    logic                              in_d;
    logic                              ab_xor;
    logic                              cd_xor;
    logic                              ab_flop_next;
    logic                              cd_flop_next;
    logic [2:0]                        ab_logic_next;
    logic [2:0]                        cd_logic_next;
    logic [2:0]                        pairs_logic_next;

    // configuration writes, always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                center_reg[i] <= qwc_pkg::CENTER_RESET;
                width_reg[i]  <= qwc_pkg::WIDTH_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index) inside
                [qwc_pkg::REG_CENTER_A:qwc_pkg::REG_CENTER_D]: begin
                    center_reg[cfg_index[1:0]] <= $signed(cfg_wdata[qwc_pkg::KNOB_W-1:0]);
                end
                [qwc_pkg::REG_WIDTH_A:qwc_pkg::REG_WIDTH_D]: begin
                    width_reg[cfg_index[1:0]] <= cfg_wdata[qwc_pkg::KNOB_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_sample_reg    <= s_sample;
            in_connected_reg <= s_connected;
            in_shift_reg     <= s_shift_cv;
            in_size_reg      <= s_size_cv;
        end
    end

    // sample selection: unconnected b, c, d reuse the previous used sample
    assign frame_end   = (pos_reg == qwc_pkg::CH_D);
    assign used_sample = (pos_reg == qwc_pkg::CH_A || in_connected_reg) ?
                         in_sample_reg : carried_reg;
    assign zone_prev   = zone_store_reg[pos_reg];

    qwc_zone #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_zone (
        .sample      (used_sample),
        .center_knob (center_reg[pos_reg]),
        .width_knob  (width_reg[pos_reg]),
        .shift_cv    (in_shift_reg),
        .size_cv     (in_size_reg),
        .zone_prev   (zone_prev),
        .zone_next   (zone_new)
    );

    // pair logic over inside flags, channel d taken from this beat
    always_comb begin
        in_a   = (zone_store_reg[0] == qwc_pkg::ZONE_INSIDE);
        in_b   = (zone_store_reg[1] == qwc_pkg::ZONE_INSIDE);
        in_c   = (zone_store_reg[2] == qwc_pkg::ZONE_INSIDE);
        in_d   = (zone_new == qwc_pkg::ZONE_INSIDE);
        ab_xor = in_a ^ in_b;
        cd_xor = in_c ^ in_d;
        ab_flop_next     = ab_flop_reg ^ (ab_xor && !ab_xor_last_reg);
        cd_flop_next     = cd_flop_reg ^ (cd_xor && !cd_xor_last_reg);
        ab_logic_next    = qwc_pkg::logic3(in_a, in_b);
        cd_logic_next    = qwc_pkg::logic3(in_c, in_d);
        pairs_logic_next = qwc_pkg::logic3(in_a | in_b, in_c | in_d);
    end

    // channel state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                zone_store_reg[i] <= qwc_pkg::ZONE_NONE;
            end
            carried_reg     <= '0;
            pos_reg         <= qwc_pkg::CH_A;
            ab_xor_last_reg <= 1'b0;
            cd_xor_last_reg <= 1'b0;
            ab_flop_reg     <= 1'b0;
            cd_flop_reg     <= 1'b0;
        end else if (advance) begin
            zone_store_reg[pos_reg] <= zone_new;
            carried_reg             <= used_sample;
            pos_reg                 <= pos_reg + 2'd1;
            if (frame_end) begin
                ab_xor_last_reg <= ab_xor;
                cd_xor_last_reg <= cd_xor;
                ab_flop_reg     <= ab_flop_next;
                cd_flop_reg     <= cd_flop_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_channel_reg     <= pos_reg;
            out_zone_reg        <= zone_new;
            out_frame_end_reg   <= frame_end;
            out_ab_logic_reg    <= frame_end ? ab_logic_next : 3'd0;
            out_ab_toggle_reg   <= frame_end && ab_flop_next;
            out_cd_logic_reg    <= frame_end ? cd_logic_next : 3'd0;
            out_cd_toggle_reg   <= frame_end && cd_flop_next;
            out_pairs_logic_reg <= frame_end ? pairs_logic_next : 3'd0;
        end
    end

    // result beat outputs
    assign m_valid       = out_valid_reg;
    assign m_channel     = out_channel_reg;
    assign m_zone        = out_zone_reg;
    assign m_frame_end   = out_frame_end_reg;
    assign m_ab_logic    = out_ab_logic_reg;
    assign m_ab_toggle   = out_ab_toggle_reg;
    assign m_cd_logic    = out_cd_logic_reg;
    assign m_cd_toggle   = out_cd_toggle_reg;
    assign m_pairs_logic = out_pairs_logic_reg;

    // assertions
    `QWC_ASSERT_IMP(a_frame_end_on_d, aclk, aresetn, out_valid_reg && out_frame_end_reg, out_channel_reg == qwc_pkg::CH_D)
    `QWC_ASSERT_IMP(a_pair_fields_idle, aclk, aresetn, out_valid_reg && !out_frame_end_reg, out_ab_logic_reg == 3'd0 && out_cd_logic_reg == 3'd0 && out_pairs_logic_reg == 3'd0 && !out_ab_toggle_reg && !out_cd_toggle_reg)
    `QWC_ASSERT_NXT(a_position_steps, aclk, aresetn, advance, pos_reg == $past(pos_reg) + 2'd1)
    `QWC_ASSERT_IMP(a_stall_holds_input, aclk, aresetn, !s_ready, in_valid_reg && out_valid_reg && !m_ready)

endmodule

`default_nettype wire

FILE: tb/window_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// window_result_checker
// watches the knob, sample and result channels of the quad window comparator,
// keeps its own copy of the knobs and the per-channel zones, predicts one
// result per accepted sample beat and compares every result beat with it
// ----------------------------------------------------------------------------
module window_result_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    input  logic                                 cfg_valid,
    input  logic                                 cfg_ready,
    input  logic [qwc_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [qwc_pkg::CFG_DATA_W-1:0]       cfg_wdata,

    input  logic                                 s_valid,
    input  logic                                 s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]       s_sample,
    input  logic                                 s_connected,
    input  logic signed [qwc_pkg::CV_W-1:0]      s_shift_cv,
    input  logic signed [qwc_pkg::CV_W-1:0]      s_size_cv,

    input  logic                                 m_valid,
    input  logic                                 m_ready,
    input  logic [1:0]                           m_channel,
    input  logic [1:0]                           m_zone,
    input  logic                                 m_frame_end,
    input  logic [2:0]                           m_ab_logic,
    input  logic                                 m_ab_toggle,
    input  logic [2:0]                           m_cd_logic,
    input  logic                                 m_cd_toggle,
    input  logic [2:0]                           m_pairs_logic,

    output int                                   mismatches,
    output int                                   pending,
    output int                                   results_seen
);

    typedef struct packed {
        logic [1:0]     channel;
        qwc_pkg::zone_t zone;
        logic           frame_end;
        logic [2:0]     ab_logic;
        logic           ab_toggle;
        logic [2:0]     cd_logic;
        logic           cd_toggle;
        logic [2:0]     pairs_logic;
    } window_result_t;

    // shadow of the knobs and of the comparator state
    logic signed [qwc_pkg::KNOB_W-1:0] knob_center [4];
    logic [qwc_pkg::KNOB_W-1:0]        knob_width  [4];
    qwc_pkg::zone_t                    zone_mem    [4];
    logic signed [SAMPLE_WIDTH-1:0]    carried_sample;
    logic [1:0]                        frame_pos;
    logic                              ab_xor_prev;
    logic                              cd_xor_prev;
    logic                              ab_flop;
    logic                              cd_flop;

    window_result_t expected_results [$];

    // bit0 and, bit1 or, bit2 xor
    function automatic logic [2:0] and_or_xor(input logic x, input logic y);
        return {x ^ y, x | y, x & y};
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // zone update of one sample beat, queues its expected result
    task automatic predict_window(
        input logic signed [SAMPLE_WIDTH-1:0]       sample,
        input logic                                 connected,
        input logic signed [qwc_pkg::CV_W-1:0]      shift_cv,
        input logic signed [qwc_pkg::CV_W-1:0]      size_cv
    );
        logic [1:0]                     ch;
        logic signed [SAMPLE_WIDTH-1:0] used;
        longint                         center;
        longint                         size;
        longint                         hi2;
        longint                         lo2;
        longint                         s2;
        qwc_pkg::zone_t                 z;
        logic                           clear_of_lo;
        logic                           clear_of_hi;
        logic                           a, b, c, d, abx, cdx;
        window_result_t                 r;

        ch = frame_pos;
        // unconnected b, c, d reuse the sample the previous channel used
        used = (ch == qwc_pkg::CH_A || connected) ? sample : carried_sample;
        carried_sample = used;

        center = longint'(knob_center[ch]) + longint'(shift_cv);
        size = longint'(knob_width[ch]) + longint'(size_cv);
        if (size < 1) begin
            size = 1;
        end
        hi2 = 2 * center + size;
        lo2 = 2 * center - size;
        s2 = 2 * longint'(used);

        // hysteresis: leave the window beyond the band, re-enter inside it
        z = zone_mem[ch];
        if (s2 > hi2 + qwc_pkg::HYST2) begin
            z = qwc_pkg::ZONE_ABOVE;
        end else if (s2 < lo2 - qwc_pkg::HYST2) begin
            z = qwc_pkg::ZONE_BELOW;
        end else begin
            clear_of_lo = (s2 >= lo2 + qwc_pkg::HYST2);
            clear_of_hi = (s2 <= hi2 - qwc_pkg::HYST2);
            if ((z == qwc_pkg::ZONE_ABOVE && clear_of_hi) ||
                (z == qwc_pkg::ZONE_BELOW && clear_of_lo) ||
                (z != qwc_pkg::ZONE_INSIDE && clear_of_lo && clear_of_hi)) begin
                z = qwc_pkg::ZONE_INSIDE;
            end
        end
        zone_mem[ch] = z;

        r = '0;
        r.channel = ch;
        r.zone = z;

        // pair logic and toggles only on the last channel of the frame
        if (ch == qwc_pkg::CH_D) begin
            a = (zone_mem[0] == qwc_pkg::ZONE_INSIDE);
            b = (zone_mem[1] == qwc_pkg::ZONE_INSIDE);
            c = (zone_mem[2] == qwc_pkg::ZONE_INSIDE);
            d = (zone_mem[3] == qwc_pkg::ZONE_INSIDE);
            abx = a ^ b;
            cdx = c ^ d;
            if (abx && !ab_xor_prev) begin
                ab_flop = !ab_flop;
            end
            ab_xor_prev = abx;
            if (cdx && !cd_xor_prev) begin
                cd_flop = !cd_flop;
            end
            cd_xor_prev = cdx;
            r.frame_end = 1'b1;
            r.ab_logic = and_or_xor(a, b);
            r.ab_toggle = ab_flop;
            r.cd_logic = and_or_xor(c, d);
            r.cd_toggle = cd_flop;
            r.pairs_logic = and_or_xor(a | b, c | d);
        end

        expected_results.push_back(r);
        frame_pos = ch + 2'd1;
    endtask

    always @(posedge aclk) begin : track_and_compare
        window_result_t got;
        window_result_t want;

        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                knob_center[i] = qwc_pkg::CENTER_RESET;
                knob_width[i] = qwc_pkg::WIDTH_RESET;
                zone_mem[i] = qwc_pkg::ZONE_NONE;
            end
            carried_sample = '0;
            frame_pos = qwc_pkg::CH_A;
            ab_xor_prev = 1'b0;
            cd_xor_prev = 1'b0;
            ab_flop = 1'b0;
            cd_flop = 1'b0;
            expected_results.delete();
        end else begin
            // knob write beat, index past the width registers is dropped
            if (cfg_valid && cfg_ready) begin
                if (cfg_index <= qwc_pkg::REG_CENTER_D) begin
                    knob_center[cfg_index[1:0]] = cfg_wdata[qwc_pkg::KNOB_W-1:0];
                end else if (cfg_index <= qwc_pkg::REG_WIDTH_D) begin
                    knob_width[cfg_index[1:0]] = cfg_wdata[qwc_pkg::KNOB_W-1:0];
                end
            end

            if (s_valid && s_ready) begin
                predict_window(s_sample, s_connected, s_shift_cv, s_size_cv);
            end

            // result beat against the oldest prediction
            if (m_valid && m_ready) begin
                got.channel = m_channel;
                got.zone = qwc_pkg::zone_t'(m_zone);
                got.frame_end = m_frame_end;
                got.ab_logic = m_ab_logic;
                got.ab_toggle = m_ab_toggle;
                got.cd_logic = m_cd_logic;
                got.cd_toggle = m_cd_toggle;
                got.pairs_logic = m_pairs_logic;
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing expected",
                                              results_seen));
                end else begin
                    want = expected_results.pop_front();
                    if (got.channel !== want.channel)
                        report_mismatch($sformatf("result %0d channel: got %0d, expected %0d",
                                                  results_seen, got.channel, want.channel));
                    if (got.zone !== want.zone)
                        report_mismatch($sformatf("result %0d zone: got %0d, expected %0d",
                                                  results_seen, got.zone, want.zone));
                    if (got.frame_end !== want.frame_end)
                        report_mismatch($sformatf("result %0d frame_end: got %0d, expected %0d",
                                                  results_seen, got.frame_end, want.frame_end));
                    if (got.ab_logic !== want.ab_logic)
                        report_mismatch($sformatf("result %0d ab_logic: got %0d, expected %0d",
                                                  results_seen, got.ab_logic, want.ab_logic));
                    if (got.ab_toggle !== want.ab_toggle)
                        report_mismatch($sformatf("result %0d ab_toggle: got %0d, expected %0d",
                                                  results_seen, got.ab_toggle, want.ab_toggle));
                    if (got.cd_logic !== want.cd_logic)
                        report_mismatch($sformatf("result %0d cd_logic: got %0d, expected %0d",
                                                  results_seen, got.cd_logic, want.cd_logic));
                    if (got.cd_toggle !== want.cd_toggle)
                        report_mismatch($sformatf("result %0d cd_toggle: got %0d, expected %0d",
                                                  results_seen, got.cd_toggle, want.cd_toggle));
                    if (got.pairs_logic !== want.pairs_logic)
                        report_mismatch($sformatf("result %0d pairs_logic: got %0d, expected %0d",
                                                  results_seen, got.pairs_logic,
                                                  want.pairs_logic));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for quad_window_comparator_logic
// drives knob writes and sample beats with random gaps and output stalls,
// a result checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module testbench;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int KNOB_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 135;
    localparam int PRESSURE_BEATS  = 24;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int QUIET_LIMIT     = 4000;

    logic                                   aclk;
    logic                                   aresetn = 1'b0;

    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [qwc_pkg::CFG_INDEX_W-1:0]        cfg_index = '0;
    logic [qwc_pkg::CFG_DATA_W-1:0]         cfg_wdata = '0;

    logic                                   s_valid = 1'b0;
    logic                                   s_ready;
    logic signed [SAMPLE_WIDTH-1:0]         s_sample = '0;
    logic                                   s_connected = 1'b0;
    logic signed [qwc_pkg::CV_W-1:0]        s_shift_cv = '0;
    logic signed [qwc_pkg::CV_W-1:0]        s_size_cv = '0;

    logic                                   m_valid;
    logic                                   m_ready = 1'b0;
    logic [1:0]                             m_channel;
    logic [1:0]                             m_zone;
    logic                                   m_frame_end;
    logic [2:0]                             m_ab_logic;
    logic                                   m_ab_toggle;
    logic [2:0]                             m_cd_logic;
    logic                                   m_cd_toggle;
    logic [2:0]                             m_pairs_logic;

    int mismatches;
    int pending;
    int results_seen;

    // stimulus bookkeeping
    int beats_sent;
    int reg_writes;
    int hold_req;
    int quiet_cycles = 0;
    bit src_eager;
    bit sink_eager;
    int center_knob [4];
    int width_knob  [4];

    quad_window_comparator_logic #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_connected  (s_connected),
        .s_shift_cv   (s_shift_cv),
        .s_size_cv    (s_size_cv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_channel    (m_channel),
        .m_zone       (m_zone),
        .m_frame_end  (m_frame_end),
        .m_ab_logic   (m_ab_logic),
        .m_ab_toggle  (m_ab_toggle),
        .m_cd_logic   (m_cd_logic),
        .m_cd_toggle  (m_cd_toggle),
        .m_pairs_logic(m_pairs_logic)
    );

    window_result_checker #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_connected  (s_connected),
        .s_shift_cv   (s_shift_cv),
        .s_size_cv    (s_size_cv),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_channel    (m_channel),
        .m_zone       (m_zone),
        .m_frame_end  (m_frame_end),
        .m_ab_logic   (m_ab_logic),
        .m_ab_toggle  (m_ab_toggle),
        .m_cd_logic   (m_cd_logic),
        .m_cd_toggle  (m_cd_toggle),
        .m_pairs_logic(m_pairs_logic),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // one sample beat, valid stays up across back-to-back beats
    task automatic send_beat(input int sample, input bit connected,
                             input int shift_cv, input int size_cv);
        int gap;
        s_valid <= 1'b1;
        s_sample <= sample[SAMPLE_WIDTH-1:0];
        s_connected <= connected;
        s_shift_cv <= shift_cv[qwc_pkg::CV_W-1:0];
        s_size_cv <= size_cv[qwc_pkg::CV_W-1:0];
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        gap = src_eager ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // random beat aimed mostly at the hysteresis bands of the current channel
    task automatic random_beat();
        int  ch, wid, shift, size, eff_c, half, smp, r;
        bit  conn;
        ch = beats_sent % 4;
        wid = width_knob[ch];
        r = $urandom_range(0, 9);
        if (r < 6) begin
            shift = int'($urandom_range(0, 2048)) - 1024;
            size = int'($urandom_range(0, 2048)) - 1024;
        end else if (r < 8) begin
            shift = 0;
            size = 0;
        end else if (r < 9) begin
            shift = int'($urandom_range(0, 65535)) - 32768;
            size = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            // pull the width down to the one lsb floor
            shift = int'($urandom_range(0, 512)) - 256;
            size = -wid - int'($urandom_range(0, 300));
            if (size < -32768) size = -32768;
        end
        eff_c = center_knob[ch] + shift;
        half = (wid + size) / 2;
        if (half < 0) half = 0;

        r = $urandom_range(0, 9);
        if (r < 5) begin
            smp = eff_c + ($urandom_range(0, 1) ? half : -half) +
                  int'($urandom_range(0, 600)) - 300;
        end else if (r < 7) begin
            smp = eff_c + int'($urandom_range(0, 2 * half + 2)) - half - 1;
        end else if (r < 9) begin
            smp = int'($urandom_range(0, 65535)) - 32768;
        end else begin
            smp = eff_c + ($urandom_range(0, 1) ? 1 : -1) *
                  (half + int'($urandom_range(150, 450)));
        end
        if (smp > 32767) smp = 32767;
        if (smp < -32768) smp = -32768;
        conn = ($urandom_range(0, 4) != 0);
        send_beat(smp, conn, shift, size);
    endtask

    // stop offering samples and wait for every result to come back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // one knob write beat, bit 15 of the data is don't-care to the block
    task automatic write_reg(input int index, input int value, input int spare);
        cfg_valid <= 1'b1;
        cfg_index <= index[qwc_pkg::CFG_INDEX_W-1:0];
        cfg_wdata <= {spare[0], value[qwc_pkg::KNOB_W-1:0]};
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        reg_writes++;
        if (index <= int'(qwc_pkg::REG_CENTER_D)) begin
            center_knob[index - int'(qwc_pkg::REG_CENTER_A)] =
                $signed(value[qwc_pkg::KNOB_W-1:0]);
        end else if (index <= int'(qwc_pkg::REG_WIDTH_D)) begin
            width_knob[index - int'(qwc_pkg::REG_WIDTH_A)] = value[qwc_pkg::KNOB_W-1:0];
        end
    endtask

    // result side: random stalls, plus one long hold on request
    initial begin : result_sink
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !sink_eager && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int phase;
        int ch;
        int cval;
        int wval;

        for (ch = 0; ch < 4; ch++) begin
            center_knob[ch] = qwc_pkg::CENTER_RESET;
            width_knob[ch] = qwc_pkg::WIDTH_RESET;
        end
        beats_sent = 0;
        reg_writes = 0;
        hold_req = 0;
        src_eager = 1'b0;
        sink_eager = 1'b0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frames on reset knobs: window +-1024 lsb, band +-205
        // from no zone: inside, held in band, above, below
        send_beat(0, 1'b1, 0, 0);
        send_beat(1000, 1'b1, 0, 0);
        send_beat(32767, 1'b1, 0, 0);
        send_beat(-32768, 1'b1, 0, 0);
        // a ignores connected, b carries a's sample, c full shift, d width floor
        send_beat(32767, 1'b0, 0, 0);
        send_beat(-5, 1'b0, 0, 0);
        send_beat(0, 1'b1, 32767, 0);
        send_beat(0, 1'b1, 0, -32768);
        // hysteresis: stay above, re-enter from above and below, stay below
        send_beat(1000, 1'b1, 0, 0);
        send_beat(800, 1'b1, 0, 0);
        send_beat(-800, 1'b1, 0, 0);
        send_beat(-1000, 1'b1, 0, 0);
        // extreme cvs, carried minimum sample, exact upper threshold and one past
        send_beat(-32768, 1'b1, -32768, 32767);
        send_beat(12345, 1'b0, 0, 0);
        send_beat(1229, 1'b1, 0, 0);
        send_beat(1230, 1'b1, 0, 0);
        // inner band edges, lower threshold, carried sample into d
        send_beat(819, 1'b1, 0, 0);
        send_beat(-819, 1'b1, 0, 0);
        send_beat(-1229, 1'b1, 0, 0);
        send_beat(7, 1'b0, 0, 0);

        for (phase = 0; phase < KNOB_PHASES; phase++) begin
            // new knob setting once the block is empty
            if (phase > 0) begin
                drain();
                for (ch = 0; ch < 4; ch++) begin
                    case (phase)
                        1: begin
                            cval = ch[0] ? 10240 : -10240;
                            wval = ch[1] ? 20480 : 0;
                        end
                        2: begin
                            cval = ch[0] ? -16384 : 16383;
                            wval = ch[1] ? 1 : 32767;
                        end
                        default: begin
                            if ($urandom_range(0, 9) < 7) begin
                                cval = int'($urandom_range(0, 20480)) - 10240;
                                wval = $urandom_range(0, 20480);
                            end else begin
                                cval = int'($urandom_range(0, 32767)) - 16384;
                                wval = $urandom_range(0, 32767);
                            end
                        end
                    endcase
                    write_reg(int'(qwc_pkg::REG_CENTER_A) + ch, cval, $urandom_range(0, 1));
                    write_reg(int'(qwc_pkg::REG_WIDTH_A) + ch, wval, $urandom_range(0, 1));
                end
                // index past the register map must leave the knobs alone
                write_reg(int'(qwc_pkg::REG_WIDTH_D) + 1 + $urandom_range(0, 7), $urandom,
                          $urandom_range(0, 1));
            end

            src_eager = (phase == 3);
            sink_eager = (phase == 3 || phase == 6);
            repeat (BEATS_PER_PHASE) random_beat();

            // hold the result side while samples keep coming, block backs up
            if (phase == 4) begin
                hold_req++;
                src_eager = 1'b1;
                repeat (PRESSURE_BEATS) random_beat();
                src_eager = 1'b0;
            end
        end

        drain();

        $display("summary: %0d sample beats over %0d knob settings, %0d register writes",
                 beats_sent, KNOB_PHASES, reg_writes);
        $display("summary: %0d results checked across window edges, width floor, %s",
                 results_seen, "unconnected channels and a long output hold");
        if (mismatches == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

FILE: quad_window_comparator_logic.f
+incdir+rtl/core
rtl/core/qwc_pkg.sv
rtl/core/qwc_zone.sv
rtl/core/quad_window_comparator_logic.sv
tb/window_result_checker.sv
tb/testbench.sv
